>>> hdl/epaic_pkg.sv
package epaic_pkg;

    // Configuration port geometry and register indexes.
    localparam int CFG_IDX_W  = 3;
    localparam int CFG_DATA_W = 15;

    localparam logic [CFG_IDX_W-1:0] CFG_RESOLUTION = 3'd0;
    localparam logic [CFG_IDX_W-1:0] CFG_POLES      = 3'd1;
    localparam logic [CFG_IDX_W-1:0] CFG_OFFSET     = 3'd2;
    localparam logic [CFG_IDX_W-1:0] CFG_TOLERANCE  = 3'd3;
    localparam logic [CFG_IDX_W-1:0] CFG_USE_INDEX  = 3'd4;

    // Register reset values.
    localparam logic [14:0] RESOLUTION_RST = 15'd14400;
    localparam logic [5:0]  POLES_RST      = 6'd1;
    localparam logic [10:0] TOLERANCE_RST  = 11'd90;

    // Serial divider geometry: a 32-bit dividend magnitude over a 15-bit divisor.
    localparam int DIV_W   = 32;
    localparam int DEN_W   = 15;
    localparam int STEP_W  = 5;
    localparam logic [STEP_W-1:0] LAST_STEP = STEP_W'(DIV_W - 1);

    // Angle arithmetic constants.
    localparam int DEG_W = 9;
    localparam logic [DEG_W-1:0] DEG_FULL = 9'd360;
    localparam logic [14:0] DEG_FULL_W = 15'd360;
    localparam logic signed [29:0] TOL_SCALE = 30'sd3600;
    localparam logic signed [17:0] COUNT_MARGIN = 18'sd16;

    typedef struct packed {
        logic signed [15:0] count_sample;
        logic               index_level;
        logic               index_event;
    } sample_t;

    typedef struct packed {
        logic [8:0]         electrical_angle;
        logic [15:0]        position_fraction;
        logic signed [15:0] corrected_count;
        logic               dirty_warning;
        logic               broken_warning;
    } result_t;

    // Sequencing of the serial units: load new operands, or advance one bit.
    typedef struct packed {
        logic load;
        logic step;
    } div_ctl_t;

endpackage

>>> hdl/epaic_sdiv.sv
module epaic_sdiv (
    input  logic                        clk,
    input  epaic_pkg::div_ctl_t         ctl,
    input  logic [epaic_pkg::DIV_W-1:0] dividend,
    input  logic [epaic_pkg::DEN_W-1:0] divisor,
    output logic [epaic_pkg::DIV_W-1:0] quotient,
    output logic                        qbit
);
    import epaic_pkg::*;

    // Restoring division, one quotient bit per step, most significant first.
    // Quotient bits shift into the low end of the dividend register.
    logic [DIV_W-1:0] num_reg;
    logic [DIV_W-1:0] num_next;
    logic [DEN_W-1:0] rem_reg;
    logic [DEN_W-1:0] rem_next;
    logic [DEN_W-1:0] den_reg;
    logic [DEN_W:0]   trial;

    always_comb
    begin
        trial    = {rem_reg, num_reg[DIV_W-1]};
        qbit     = (trial >= {1'b0, den_reg});
        rem_next = qbit ? DEN_W'(trial - {1'b0, den_reg}) : trial[DEN_W-1:0];
        num_next = {num_reg[DIV_W-2:0], qbit};
    end

    always_ff @(posedge clk)
    begin
        if (ctl.load)
        begin
            num_reg <= dividend;
            rem_reg <= '0;
            den_reg <= divisor;
        end
        else if (ctl.step)
        begin
            num_reg <= num_next;
            rem_reg <= rem_next;
        end
    end

    assign quotient = num_reg;

endmodule

>>> hdl/epaic_mod360.sv
module epaic_mod360 (
    input  logic                        clk,
    input  epaic_pkg::div_ctl_t         ctl,
    input  logic                        qbit,
    output logic [epaic_pkg::DEG_W-1:0] residue
);
    import epaic_pkg::*;

    // Running remainder modulo 360 of a value that arrives one bit per step,
    // most significant bit first.
    logic [DEG_W-1:0] r_reg;
    logic [DEG_W-1:0] r_next;
    logic [DEG_W:0]   t;

    always_comb
    begin
        t      = {r_reg, qbit};
        r_next = (t >= {1'b0, DEG_FULL}) ? DEG_W'(t - {1'b0, DEG_FULL}) : t[DEG_W-1:0];
    end

    always_ff @(posedge clk)
    begin
        if (ctl.load)
        begin
            r_reg <= '0;
        end
        else if (ctl.step)
        begin
            r_reg <= r_next;
        end
    end

    assign residue = r_reg;

endmodule

>>> hdl/encoder_position_angle_index_check.sv
// Quadrature encoder position to electrical angle with index checks. Each request
// carries one counter sample with the index pin level and an index event flag, and
// yields one result: the electrical angle in degrees (offset plus
// count * 360 * poles / resolution, wrapped into 0..359), the position as a 16-bit
// fraction of a revolution, the corrected count and the dirty and broken index
// warnings. After a request is accepted, the block passes through a multiplication
// state, an index check state, a division state in which two bit-serial restoring
// dividers run side by side (the angle quotient and the position fraction, both
// over the resolution), and a final state that assembles the result and loads it
// into the result register. The angle quotient is reduced modulo 360 bit by bit as
// its quotient bits come out of the divider. A new request is taken once the
// previous one has moved into the output register, which holds the result while
// the receiver stalls; a stall still on when the next result is ready keeps the
// block in its final state and delays the next request. Configuration is
// written through its own port, which is always ready, and should only be written
// while no request is in flight; a resolution of zero is treated as one.
module encoder_position_angle_index_check (
    input  logic                            clk,
    input  logic                            rst_n,
    input  logic                            sample_valid,
    output logic                            sample_stall,
    input  epaic_pkg::sample_t              sample,
    output logic                            result_valid,
    input  logic                            result_stall,
    output epaic_pkg::result_t              result,
    input  logic                            cfg_valid,
    output logic                            cfg_ready,
    input  logic [epaic_pkg::CFG_IDX_W-1:0] cfg_index,
    input  logic [epaic_pkg::CFG_DATA_W-1:0] cfg_data
);
    import epaic_pkg::*;

    typedef enum logic [4:0] {
        S_IDLE  = 5'b00001,
        S_MUL   = 5'b00010,
        S_CHECK = 5'b00100,
        S_DIV   = 5'b01000,
        S_FIN   = 5'b10000
    } state_t;

    state_t state_reg;
    state_t state_next;
    logic [STEP_W-1:0] cnt_reg;
    logic [STEP_W-1:0] cnt_next;

    // Configuration registers.
    logic [14:0]        res_reg;
    logic [5:0]         poles_reg;
    logic signed [9:0]  offset_reg;
    logic [10:0]        tol_reg;
    logic               use_index_reg;

    // Block state that persists across requests.
    logic               index_seen_reg;
    logic               index_seen_next;
    logic signed [15:0] prev_reg;
    logic signed [15:0] prev_next;

    // Per-request working registers.
    sample_t            smp_reg;
    logic [31:0]        prod_reg;
    logic [25:0]        x_reg;
    logic signed [29:0] p1_reg;
    logic signed [29:0] p2_reg;
    logic signed [15:0] count_out_reg;
    logic               dirty_reg;
    logic               broken_reg;

    result_t            result_reg;
    result_t            result_next;
    logic               result_valid_reg;
    logic               result_valid_next;

    logic               sample_accept;
    logic               fin_load;
    logic [14:0]        res_eff;

    // Multiplication stage.
    logic [15:0]        mag_s;
    logic [14:0]        deg_mult;
    logic signed [17:0] diff;

    // Index check stage.
    logic               seen_now;
    logic               checks_on;
    logic signed [17:0] cs;
    logic signed [17:0] res18;
    logic signed [17:0] c1;
    logic signed [17:0] c2;
    logic signed [29:0] x_s;
    logic               out_range;
    logic               dirty_now;
    logic               broken_now;
    logic signed [15:0] count_now;
    logic [15:0]        cmag;

    // Serial units.
    div_ctl_t           div_ctl;
    logic [DIV_W-1:0]   deg_quot;
    logic [DIV_W-1:0]   frac_quot;
    logic               deg_qbit;
    logic               frac_qbit;
    logic [DEG_W-1:0]   deg_residue;

    // Result assembly.
    logic [DEG_W-1:0]   qm;
    logic signed [10:0] o;
    logic signed [10:0] o2;
    logic [DEG_W:0]     s;
    logic [DEG_W-1:0]   angle;
    logic [15:0]        frac;

    assign cfg_ready     = 1'b1;
    assign sample_stall  = (state_reg != S_IDLE);
    assign sample_accept = sample_valid && !sample_stall;
    assign res_eff       = (res_reg == '0) ? 15'd1 : res_reg;

    // Multiplications: the angle numerator magnitude, the threshold product, and
    // the previous count terms scaled by 3600 so that the threshold compares need
    // no division.
    always_comb
    begin
        mag_s    = smp_reg.count_sample[15] ? 16'(16'd0 - $unsigned(smp_reg.count_sample))
                                            : $unsigned(smp_reg.count_sample);
        deg_mult = 15'(poles_reg) * DEG_FULL_W;
        diff     = $signed({3'b000, res_eff}) - 18'(prev_reg);
    end

    // Index checks and the broken-index wrap.
    always_comb
    begin
        seen_now   = index_seen_reg | (use_index_reg & smp_reg.index_event);
        checks_on  = use_index_reg & seen_now;
        cs         = 18'(smp_reg.count_sample);
        res18      = $signed({3'b000, res_eff});
        x_s        = $signed({4'b0000, x_reg});
        out_range  = (cs < -COUNT_MARGIN) || (cs > (res18 + COUNT_MARGIN));
        // The dirty window threshold < prev < resolution - threshold, with both
        // sides multiplied through by 3600.
        dirty_now  = checks_on & smp_reg.index_level & (x_s < p1_reg) & (x_s < p2_reg);
        broken_now = checks_on & ~smp_reg.index_level & out_range;
        c1         = (cs < 18'sd0) ? (cs + res18) : cs;
        c2         = (c1 >= res18) ? (c1 - res18) : c1;
        count_now  = broken_now ? $signed(c2[15:0]) : smp_reg.count_sample;
        cmag       = count_now[15] ? 16'(16'd0 - $unsigned(count_now)) : $unsigned(count_now);
    end

    always_comb
    begin
        div_ctl.load = (state_reg == S_CHECK);
        div_ctl.step = (state_reg == S_DIV);
    end

    epaic_sdiv u_deg_div (
        .clk      (clk),
        .ctl      (div_ctl),
        .dividend (prod_reg),
        .divisor  (res_eff),
        .quotient (deg_quot),
        .qbit     (deg_qbit)
    );

    epaic_sdiv u_frac_div (
        .clk      (clk),
        .ctl      (div_ctl),
        .dividend ({cmag, 16'h0000}),
        .divisor  (res_eff),
        .quotient (frac_quot),
        .qbit     (frac_qbit)
    );

    epaic_mod360 u_deg_mod (
        .clk     (clk),
        .ctl     (div_ctl),
        .qbit    (deg_qbit),
        .residue (deg_residue)
    );

    // Result assembly. The angle quotient residue takes the sign of the sample, the
    // offset is reduced into 0..359 on its own, and one final subtract folds the sum.
    always_comb
    begin
        if (smp_reg.count_sample[15] && (deg_residue != '0))
        begin
            qm = DEG_W'(DEG_FULL - deg_residue);
        end
        else
        begin
            qm = deg_residue;
        end
        o = 11'(offset_reg);
        if (o < 11'sd0)
        begin
            o2 = (o >= -11'sd360) ? (o + 11'sd360) : (o + 11'sd720);
        end
        else
        begin
            o2 = (o >= 11'sd360) ? (o - 11'sd360) : o;
        end
        s     = {1'b0, qm} + {1'b0, o2[DEG_W-1:0]};
        angle = (s >= {1'b0, DEG_FULL}) ? DEG_W'(s - {1'b0, DEG_FULL}) : s[DEG_W-1:0];
        frac  = count_out_reg[15] ? 16'(16'd0 - frac_quot[15:0]) : frac_quot[15:0];

        result_next.electrical_angle  = angle;
        result_next.position_fraction = frac;
        result_next.corrected_count   = count_out_reg;
        result_next.dirty_warning     = dirty_reg;
        result_next.broken_warning    = broken_reg;
    end

    assign fin_load = (state_reg == S_FIN) && (!result_valid_reg || !result_stall);

    always_comb
    begin
        state_next      = state_reg;
        cnt_next        = cnt_reg;
        index_seen_next = index_seen_reg;
        prev_next       = prev_reg;
        case (state_reg)
            S_IDLE:
            begin
                if (sample_accept)
                begin
                    state_next = S_MUL;
                end
            end
            S_MUL:
            begin
                state_next = S_CHECK;
            end
            S_CHECK:
            begin
                index_seen_next = seen_now;
                if (checks_on)
                begin
                    prev_next = count_now;
                end
                cnt_next   = '0;
                state_next = S_DIV;
            end
            S_DIV:
            begin
                cnt_next = cnt_reg + 1'b1;
                if (cnt_reg == LAST_STEP)
                begin
                    state_next = S_FIN;
                end
            end
            S_FIN:
            begin
                if (fin_load)
                begin
                    state_next = S_IDLE;
                end
            end
            default:
            begin
                state_next = S_IDLE;
            end
        endcase

        result_valid_next = result_valid_reg && result_stall;
        if (fin_load)
        begin
            result_valid_next = 1'b1;
        end
    end

    // Control, configuration and persistent state.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg        <= S_IDLE;
            cnt_reg          <= '0;
            res_reg          <= RESOLUTION_RST;
            poles_reg        <= POLES_RST;
            offset_reg       <= '0;
            tol_reg          <= TOLERANCE_RST;
            use_index_reg    <= 1'b0;
            index_seen_reg   <= 1'b0;
            prev_reg         <= '0;
            result_valid_reg <= 1'b0;
        end
        else
        begin
            state_reg        <= state_next;
            cnt_reg          <= cnt_next;
            index_seen_reg   <= index_seen_next;
            prev_reg         <= prev_next;
            result_valid_reg <= result_valid_next;
            if (cfg_valid && cfg_ready)
            begin
                case (cfg_index)
                    CFG_RESOLUTION: res_reg       <= cfg_data[14:0];
                    CFG_POLES:      poles_reg     <= cfg_data[5:0];
                    CFG_OFFSET:     offset_reg    <= $signed(cfg_data[9:0]);
                    CFG_TOLERANCE:  tol_reg       <= cfg_data[10:0];
                    CFG_USE_INDEX:  use_index_reg <= cfg_data[0];
                    default:        ;
                endcase
            end
        end
    end

    // Payload registers.
    always_ff @(posedge clk)
    begin
        if (sample_accept)
        begin
            smp_reg <= sample;
        end
        if (state_reg == S_MUL)
        begin
            prod_reg <= 32'(mag_s) * 32'(deg_mult);
            x_reg    <= 26'(res_eff) * 26'(tol_reg);
            p1_reg   <= 30'(prev_reg) * TOL_SCALE;
            p2_reg   <= 30'(diff) * TOL_SCALE;
        end
        if (state_reg == S_CHECK)
        begin
            count_out_reg <= count_now;
            dirty_reg     <= dirty_now;
            broken_reg    <= broken_now;
        end
        if (fin_load)
        begin
            result_reg <= result_next;
        end
    end

    assign result_valid = result_valid_reg;
    assign result       = result_reg;

endmodule
